[hdl/snfc_pkg.sv]
package snfc_pkg;

    localparam int ADDR_BITS_DEF    = 21;
    localparam int SECTOR_BYTES_DEF = 4096;

    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_PROG  = 8'h02;
    localparam logic [7:0] CMD_ERASE = 8'h20;
    localparam logic [7:0] CMD_RDID  = 8'h9F;
    localparam logic [7:0] BYTE_FF   = 8'hFF;

    localparam logic CFG_JEDEC  = 1'b0;
    localparam logic CFG_STATUS = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ID    = 3'd1,
        PH_RDSR  = 3'd2,
        PH_READ  = 3'd3,
        PH_PROG  = 3'd4,
        PH_ERASE = 3'd5
    } t_phase;

    // work handed from decode to the array engine
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_ERASE = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [23:0] addr;
        logic [7:0]  data;   // answer byte, or program data
    } t_job;

    typedef enum logic [1:0] {
        BE_CLEAR = 2'd0,
        BE_RUN   = 2'd1,
        BE_READ  = 2'd2,
        BE_ERASE = 2'd3
    } t_bstate;

endpackage

[hdl/spi_nor_flash_command_model_top.sv]
// SPI NOR flash byte model. Raise start with i_req_type/i_mosi_byte; a transfer
// is taken at an edge where busy is low. Each byte transfer answers one
// o_miso_byte marked by a one-cycle o_valid, a deselect answers nothing. The
// receiver cannot stall: an answer must be taken in the cycle it appears.
// An answer passes the hold register and the output register; a read passes
// the registered memory read too. busy is high until the back end is free: a
// byte is taken once the last left the hold register and any read is done, a
// deselect does not raise busy. An erase sweeps its sector, if inside the array,
// one byte per cycle with busy high from its answer until the sweep ends.
// After reset the array is filled with 0xFF one byte a cycle, busy high until
// it is full. Configuration writes are taken at any time (o_cfg_ready is tied
// high); make them only while nothing is in flight.
module spi_nor_flash_command_model_top #(
    parameter int ADDR_BITS    = snfc_pkg::ADDR_BITS_DEF,
    parameter int SECTOR_BYTES = snfc_pkg::SECTOR_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [7:0]  i_mosi_byte,
    output logic        o_valid,
    output logic [7:0]  o_miso_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    logic [23:0]    r_jedec;
    logic [7:0]     r_status;
    logic           w_take, w_push, w_pop, w_qvalid, w_idle;
    snfc_pkg::t_job w_fjob, w_qjob;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jedec  <= 24'd15675413;
            r_status <= 8'h00;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                snfc_pkg::CFG_JEDEC:  r_jedec  <= i_cfg_data;
                snfc_pkg::CFG_STATUS: r_status <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign busy   = !w_idle || w_qvalid;
    assign w_take = start && !busy;
    assign w_push = w_take && !i_req_type;

    snfc_front #(.ADDR_BITS(ADDR_BITS)) u_front (
        .i_clk, .i_rst_n, .i_take(w_take), .i_req_type, .i_mosi_byte,
        .i_jedec_id(r_jedec), .i_status_byte(r_status), .o_job(w_fjob)
    );

    snfc_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_job(w_fjob), .i_pop(w_pop),
        .o_valid(w_qvalid), .o_job(w_qjob)
    );

    snfc_back #(.ADDR_BITS(ADDR_BITS), .SECTOR_BYTES(SECTOR_BYTES)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qvalid), .i_job(w_qjob), .o_pop(w_pop),
        .o_idle(w_idle), .o_strobe(o_valid), .o_miso_byte
    );

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> busy) else $error("accepted while queued");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qvalid) else $error("pop of empty queue");
    a_dsel_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_req_type) |=> !w_qvalid) else $error("deselect queued");
`endif
endmodule

[hdl/snfc_front.sv]
module snfc_front #(
    parameter int ADDR_BITS = snfc_pkg::ADDR_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_req_type,
    input  logic [7:0]        i_mosi_byte,
    input  logic [23:0]       i_jedec_id,
    input  logic [7:0]        i_status_byte,
    output snfc_pkg::t_job    o_job
);
    localparam logic [23:0] MASK = 24'((64'd1 << ADDR_BITS) - 64'd1);

    snfc_pkg::t_phase r_phase, n_phase;
    logic [23:0] r_addr, n_addr;
    logic [1:0]  r_seen, n_seen;
    logic [1:0]  r_idx, n_idx;
    logic        r_wen, n_wen;
    logic [23:0] w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= snfc_pkg::PH_IDLE;
            r_addr  <= '0;
            r_seen  <= '0;
            r_idx   <= '0;
            r_wen   <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_seen  <= n_seen;
            r_idx   <= n_idx;
            r_wen   <= n_wen;
        end
    end

    assign w_sh = {r_addr[15:0], i_mosi_byte};

    always_comb begin
        n_phase = r_phase;
        n_addr  = r_addr;
        n_seen  = r_seen;
        n_idx   = r_idx;
        n_wen   = r_wen;
        o_job   = '{op: snfc_pkg::OP_NONE, addr: '0, data: 8'h00};
        if (i_req_type) begin
            n_phase = snfc_pkg::PH_IDLE;
            n_seen  = '0;
        end else begin
            case (r_phase)
                snfc_pkg::PH_IDLE: begin
                    n_addr = '0;
                    n_seen = '0;
                    n_idx  = '0;
                    case (i_mosi_byte)
                        snfc_pkg::CMD_RDID:  n_phase = snfc_pkg::PH_ID;
                        snfc_pkg::CMD_RDSR:  n_phase = snfc_pkg::PH_RDSR;
                        snfc_pkg::CMD_WREN:  n_wen = 1'b1;
                        snfc_pkg::CMD_READ:  n_phase = snfc_pkg::PH_READ;
                        snfc_pkg::CMD_PROG:  n_phase = snfc_pkg::PH_PROG;
                        snfc_pkg::CMD_ERASE: n_phase = snfc_pkg::PH_ERASE;
                        default: o_job.data = snfc_pkg::BYTE_FF;
                    endcase
                end
                snfc_pkg::PH_ID: begin
                    case (r_idx)
                        2'd0: o_job.data = i_jedec_id[23:16];
                        2'd1: o_job.data = i_jedec_id[15:8];
                        2'd2: o_job.data = i_jedec_id[7:0];
                        default: begin
                            o_job.data = snfc_pkg::BYTE_FF;
                            n_phase    = snfc_pkg::PH_IDLE;
                        end
                    endcase
                    if (r_idx != 2'd3) n_idx = r_idx + 2'd1;
                end
                snfc_pkg::PH_RDSR: begin
                    o_job.data = i_status_byte;
                    n_phase    = snfc_pkg::PH_IDLE;
                end
                snfc_pkg::PH_READ, snfc_pkg::PH_PROG: begin
                    if (r_seen != 2'd3) begin
                        n_seen = r_seen + 2'd1;
                        n_addr = (r_seen == 2'd2) ? (w_sh & MASK) : w_sh;
                    end else begin
                        n_addr = (r_addr + 24'd1) & MASK;
                        o_job.addr = r_addr;
                        if (r_phase == snfc_pkg::PH_READ) begin
                            o_job.op = snfc_pkg::OP_READ;
                        end else begin
                            o_job.data = 8'h00;
                            if (r_wen) begin
                                o_job.op   = snfc_pkg::OP_WRITE;
                                o_job.data = i_mosi_byte;
                            end
                        end
                    end
                end
                snfc_pkg::PH_ERASE: begin
                    if (r_seen != 2'd3) begin
                        n_seen = r_seen + 2'd1;
                        n_addr = w_sh;
                        if (r_seen == 2'd2) begin
                            if (r_wen) begin
                                o_job.op   = snfc_pkg::OP_ERASE;
                                o_job.addr = w_sh;
                            end
                            n_wen   = 1'b0;
                            n_phase = snfc_pkg::PH_IDLE;
                        end
                    end else begin
                        n_phase = snfc_pkg::PH_IDLE;
                    end
                end
                default: begin
                    o_job.data = snfc_pkg::BYTE_FF;
                    n_phase    = snfc_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/snfc_queue.sv]
module snfc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  snfc_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output snfc_pkg::t_job o_job
);
    // one-entry hold register between decode and array engine
    logic           r_valid;
    snfc_pkg::t_job r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_job <= i_job;
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule

[hdl/snfc_back.sv]
module snfc_back #(
    parameter int ADDR_BITS    = snfc_pkg::ADDR_BITS_DEF,
    parameter int SECTOR_BYTES = snfc_pkg::SECTOR_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  snfc_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_idle,
    output logic           o_strobe,
    output logic [7:0]     o_miso_byte
);
    localparam int  DEPTH  = 1 << ADDR_BITS;
    localparam int  SBITS  = $clog2(SECTOR_BYTES);
    localparam int  CBITS  = (SBITS < ADDR_BITS) ? SBITS : ADDR_BITS;

    logic [7:0] r_mem [DEPTH];
    snfc_pkg::t_bstate r_st, n_st;
    logic [ADDR_BITS:0]   r_ptr, n_ptr;
    logic [CBITS:0]       r_cnt, n_cnt;
    logic                 w_we;
    logic [ADDR_BITS-1:0] w_wa;
    logic [7:0]           w_wd;
    logic [ADDR_BITS-1:0] w_ra;
    logic [7:0]           r_rd;
    logic                 r_strobe, n_strobe;
    logic [7:0]           r_out, n_out;
    logic                 w_sel_mem, r_sel_mem;
    logic [23:0]          w_start;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= snfc_pkg::BE_CLEAR;
            r_ptr     <= '0;
            r_cnt     <= '0;
            r_strobe  <= 1'b0;
            r_sel_mem <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_ptr     <= n_ptr;
            r_cnt     <= n_cnt;
            r_strobe  <= n_strobe;
            r_sel_mem <= w_sel_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign w_start = i_job.addr & ~24'(SECTOR_BYTES - 1);
    assign w_ra    = i_job.addr[ADDR_BITS-1:0];

    always_comb begin
        n_st      = r_st;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_strobe  = 1'b0;
        n_out     = i_job.data;
        o_pop     = 1'b0;
        w_we      = 1'b0;
        w_wa      = r_ptr[ADDR_BITS-1:0];
        w_wd      = snfc_pkg::BYTE_FF;
        w_sel_mem = 1'b0;
        case (r_st)
            snfc_pkg::BE_CLEAR: begin
                w_we  = 1'b1;
                n_ptr = r_ptr + (ADDR_BITS + 1)'(1);
                if (r_ptr == (ADDR_BITS + 1)'(DEPTH - 1)) n_st = snfc_pkg::BE_RUN;
            end
            snfc_pkg::BE_RUN: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    case (i_job.op)
                        snfc_pkg::OP_READ: begin
                            w_sel_mem = 1'b1;
                            n_st      = snfc_pkg::BE_READ;
                        end
                        snfc_pkg::OP_WRITE: begin
                            w_we     = 1'b1;
                            w_wa     = i_job.addr[ADDR_BITS-1:0];
                            w_wd     = i_job.data;
                            n_strobe = 1'b1;
                            n_out    = 8'h00;
                        end
                        snfc_pkg::OP_ERASE: begin
                            n_strobe = 1'b1;
                            n_out    = 8'h00;
                            if ((w_start >> ADDR_BITS) == 24'd0) begin
                                n_ptr = {1'b0, w_start[ADDR_BITS-1:0]};
                                n_cnt = '0;
                                n_st  = snfc_pkg::BE_ERASE;
                            end
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            snfc_pkg::BE_READ: begin
                // memory data registered now; present next cycle
                n_strobe = 1'b1;
                n_st     = snfc_pkg::BE_RUN;
            end
            snfc_pkg::BE_ERASE: begin
                w_we  = 1'b1;
                n_ptr = r_ptr + (ADDR_BITS + 1)'(1);
                n_cnt = r_cnt + (CBITS + 1)'(1);
                if (r_cnt == (CBITS + 1)'((1 << CBITS) - 1)
                    || r_ptr == (ADDR_BITS + 1)'(DEPTH - 1)) begin
                    n_st = snfc_pkg::BE_RUN;
                end
            end
            default: n_st = snfc_pkg::BE_RUN;
        endcase
    end

    logic r_rd_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_pend <= 1'b0;
        else          r_rd_pend <= r_sel_mem;
    end

    assign o_idle      = (r_st == snfc_pkg::BE_RUN) && !i_valid;
    assign o_strobe    = r_strobe;
    assign o_miso_byte = r_rd_pend ? r_rd : r_out;
endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int ADDR_BITS    = snfc_pkg::ADDR_BITS_DEF;
    localparam int SECTOR_BYTES = snfc_pkg::SECTOR_BYTES_DEF;
    localparam int MEM_BYTES    = 1 << ADDR_BITS;
    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam int ITEMS_PER_PHASE = 650;

    typedef struct {
        bit       desel;
        bit [7:0] mosi;
    } t_xfer;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_req_type;
    logic [7:0]  i_mosi_byte;
    logic        o_valid;
    logic [7:0]  o_miso_byte;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [23:0] i_cfg_data;

    spi_nor_flash_command_model_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_mosi_byte (i_mosi_byte),
        .o_valid     (o_valid),
        .o_miso_byte (o_miso_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_xfer     pending_xfers[$];
    bit [7:0]  miso_expected[$];
    int        mismatches;
    int        idle_pct;
    int        seq_items;

    // shadow of the chip
    bit [23:0] jedec_id_sh;
    bit [7:0]  status_sh;
    snfc_pkg::t_phase ph;
    bit [23:0] addr;
    int        addr_seen;
    int        id_idx;
    bit        wel;
    bit [7:0]  flash_mem[int];

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic bit [7:0] mem_rd(input int a);
        return flash_mem.exists(a) ? flash_mem[a] : snfc_pkg::BYTE_FF;
    endfunction

    function automatic bit take_addr(input bit [7:0] b);
        addr = {addr[15:0], b};
        addr_seen++;
        return addr_seen >= 3;
    endfunction

    function automatic void sector_erase();
        int base;
        base = int'(addr) & ~(SECTOR_BYTES - 1);
        if (wel && base < MEM_BYTES)
            for (int i = 0; i < SECTOR_BYTES && base + i < MEM_BYTES; i++)
                flash_mem.delete(base + i);
        wel = 1'b0;
        ph  = snfc_pkg::PH_IDLE;
    endfunction

    // expected answer for one accepted transfer
    function automatic void flash_step(input bit desel, input bit [7:0] b);
        bit [7:0] ans;
        if (desel) begin
            ph = snfc_pkg::PH_IDLE;
            addr_seen = 0;
            return;
        end
        ans = 8'h00;
        case (ph)
            snfc_pkg::PH_IDLE: begin
                addr = '0;
                addr_seen = 0;
                id_idx = 0;
                case (b)
                    snfc_pkg::CMD_RDID:  ph = snfc_pkg::PH_ID;
                    snfc_pkg::CMD_RDSR:  ph = snfc_pkg::PH_RDSR;
                    snfc_pkg::CMD_WREN: begin
                        wel = 1'b1;
                        ph = snfc_pkg::PH_IDLE;
                    end
                    snfc_pkg::CMD_READ:  ph = snfc_pkg::PH_READ;
                    snfc_pkg::CMD_PROG:  ph = snfc_pkg::PH_PROG;
                    snfc_pkg::CMD_ERASE: ph = snfc_pkg::PH_ERASE;
                    default: begin
                        ph = snfc_pkg::PH_IDLE;
                        ans = snfc_pkg::BYTE_FF;
                    end
                endcase
            end
            snfc_pkg::PH_ID: begin
                if (id_idx >= 3) begin
                    ph = snfc_pkg::PH_IDLE;
                    ans = snfc_pkg::BYTE_FF;
                end else begin
                    ans = jedec_id_sh[23 - 8*id_idx -: 8];
                    id_idx++;
                end
            end
            snfc_pkg::PH_RDSR: begin
                ph = snfc_pkg::PH_IDLE;
                ans = status_sh;
            end
            snfc_pkg::PH_READ, snfc_pkg::PH_PROG: begin
                if (addr_seen < 3) begin
                    if (take_addr(b))
                        addr = addr & 24'(MEM_BYTES - 1);
                end else begin
                    if (ph == snfc_pkg::PH_READ)
                        ans = mem_rd(int'(addr));
                    else if (wel)
                        flash_mem[int'(addr)] = b;
                    addr = (addr + 24'd1) & 24'(MEM_BYTES - 1);
                end
            end
            snfc_pkg::PH_ERASE: begin
                if (addr_seen < 3) begin
                    if (take_addr(b))
                        sector_erase();
                end else begin
                    ph = snfc_pkg::PH_IDLE;
                end
            end
            default: begin
                ph = snfc_pkg::PH_IDLE;
                ans = snfc_pkg::BYTE_FF;
            end
        endcase
        miso_expected.push_back(ans);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // hold until the transfer goes through
        end else begin
            if (start) begin
                flash_step(i_req_type, i_mosi_byte);
                void'(pending_xfers.pop_front());
            end
            if (pending_xfers.size() > 0 && $urandom_range(99) >= idle_pct) begin
                start       <= 1'b1;
                i_req_type  <= pending_xfers[0].desel;
                i_mosi_byte <= pending_xfers[0].mosi;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (miso_expected.size() == 0)
                report_mismatch($sformatf("unexpected miso %02h", o_miso_byte));
            else if (miso_expected.pop_front() != o_miso_byte)
                report_mismatch($sformatf("miso %02h differs from predicted", o_miso_byte));
        end
    end

    int cycles;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic send(input bit desel, input bit [7:0] b);
        t_xfer x;
        x.desel = desel;
        x.mosi  = b;
        pending_xfers.push_back(x);
        seq_items++;
    endtask

    task automatic send_addr(input bit [23:0] a);
        send(1'b0, a[23:16]);
        send(1'b0, a[15:8]);
        send(1'b0, a[7:0]);
    endtask

    task automatic wait_idle();
        wait (pending_xfers.size() == 0 && miso_expected.size() == 0);
        do @(posedge i_clk); while (busy || start);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input bit [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == snfc_pkg::CFG_JEDEC)
            jedec_id_sh = val;
        else
            status_sh = val[7:0];
        i_cfg_valid <= 1'b0;
    endtask

    function automatic bit [23:0] pick_addr();
        case ($urandom_range(9))
            0, 1: return 24'($urandom_range(24'hFFFFFF));
            2:    return 24'(MEM_BYTES - 1 - int'($urandom_range(40)));
            default: return 24'($urandom_range(3) * 24'h7F000 + $urandom_range(300));
        endcase
    endfunction

    task automatic random_seq();
        bit [7:0] cmd;
        int n;
        case ($urandom_range(19))
            0, 1:  send(1'b0, snfc_pkg::CMD_WREN);
            2:     send(1'b0, snfc_pkg::CMD_RDSR);
            3: begin
                send(1'b0, snfc_pkg::CMD_RDID);
                n = $urandom_range(5);
                repeat (n) send(1'b0, 8'($urandom_range(255)));
            end
            4, 5, 6, 7: begin
                send(1'b0, snfc_pkg::CMD_READ);
                send_addr(pick_addr());
                n = $urandom_range(8);
                repeat (n) send(1'b0, 8'($urandom_range(255)));
            end
            8, 9, 10, 11: begin
                if ($urandom_range(3) != 0) send(1'b0, snfc_pkg::CMD_WREN);
                send(1'b0, snfc_pkg::CMD_PROG);
                send_addr(pick_addr());
                n = $urandom_range(8);
                repeat (n) send(1'b0, 8'($urandom_range(255)));
            end
            12: begin
                if ($urandom_range(3) != 0) send(1'b0, snfc_pkg::CMD_WREN);
                send(1'b0, snfc_pkg::CMD_ERASE);
                send_addr(pick_addr());
            end
            13, 14: begin
                // broken: deselect inside a command or address
                send(1'b0, snfc_pkg::CMD_READ);
                n = $urandom_range(2);
                repeat (n) send(1'b0, 8'($urandom_range(255)));
                send(1'b1, 8'($urandom_range(255)));
            end
            default: begin
                cmd = 8'($urandom_range(255));
                send(1'b0, cmd);
                n = $urandom_range(3);
                repeat (n) send(1'b0, 8'($urandom_range(255)));
            end
        endcase
        if ($urandom_range(4) != 0)
            send(1'b1, 8'($urandom_range(255)));
    endtask

    task automatic random_phase(input int pct);
        idle_pct  = pct;
        seq_items = 0;
        while (seq_items < ITEMS_PER_PHASE)
            random_seq();
        wait_idle();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req_type  = 1'b0;
        i_mosi_byte = 8'h00;
        i_cfg_valid = 1'b0;
        i_cfg_index = snfc_pkg::CFG_JEDEC;
        i_cfg_data  = '0;
        mismatches  = 0;
        cycles      = 0;
        idle_pct    = 0;
        jedec_id_sh = 24'hEF3015;
        status_sh   = 8'h00;
        ph          = snfc_pkg::PH_IDLE;
        addr        = '0;
        addr_seen   = 0;
        id_idx      = 0;
        wel         = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // array clear pass after reset
        do @(posedge i_clk); while (busy);
        repeat (4) @(posedge i_clk);

        // directed, reset configuration
        send(1'b0, snfc_pkg::CMD_RDSR);  send(1'b0, 8'hA5);
        send(1'b0, snfc_pkg::CMD_RDID);
        repeat (5) send(1'b0, 8'h00);
        send(1'b0, 8'h00);     send(1'b0, snfc_pkg::BYTE_FF);
        send(1'b0, snfc_pkg::CMD_PROG);  send_addr(24'hFFFFFF); send(1'b0, 8'h12);
        send(1'b1, 8'hFF);
        send(1'b0, snfc_pkg::CMD_WREN);
        send(1'b0, snfc_pkg::CMD_PROG);  send_addr(24'h1FFFFF);
        send(1'b0, 8'hAB);     send(1'b0, 8'h00);
        send(1'b1, 8'h00);
        send(1'b0, snfc_pkg::CMD_READ);  send_addr(24'hFFFFFF);
        send(1'b0, 8'h00);     send(1'b0, 8'h00);
        send(1'b1, 8'h00);
        send(1'b0, snfc_pkg::CMD_ERASE); send_addr(24'hFFF000);
        send(1'b0, snfc_pkg::CMD_WREN);
        send(1'b0, snfc_pkg::CMD_ERASE); send_addr(24'h1FF000);
        send(1'b0, snfc_pkg::CMD_READ);  send_addr(24'h1FFFFF); send(1'b0, 8'h00);
        send(1'b1, 8'h00);
        wait_idle();

        cfg_write(snfc_pkg::CFG_JEDEC, 24'hFFFFFF);
        cfg_write(snfc_pkg::CFG_STATUS, 24'h0000FF);
        random_phase(34);
        cfg_write(snfc_pkg::CFG_JEDEC, 24'h000000);
        cfg_write(snfc_pkg::CFG_STATUS, 24'h000000);
        random_phase(80);
        cfg_write(snfc_pkg::CFG_JEDEC, 24'($urandom_range(24'hFFFFFF)));
        cfg_write(snfc_pkg::CFG_STATUS, 24'($urandom_range(255)));
        random_phase(0);

        wait_idle();
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

[spi_nor_flash_command_model_top.f]
hdl/snfc_pkg.sv
hdl/snfc_front.sv
hdl/snfc_queue.sv
hdl/snfc_back.sv
hdl/spi_nor_flash_command_model_top.sv
verif/tb_top.sv
